/* rtl/barometric_pressure_compensation_defines.svh */
// assertion macros used by the top-level rtl file
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define BPC_ASSERT_NOW(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("assertion failed");
// next-cycle implication, checked out of reset
`define BPC_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define BPC_ASSERT_NOW(label, clk, rstn, cond, prop)
`define BPC_ASSERT_NEXT(label, clk, rstn, cond, prop)
`endif

`endif

/* rtl/bpc_pkg.sv */
`default_nettype none
package bpc_pkg;

    // one quotient bit per divider stage
    localparam int DIV_STAGES = 32;
    // register stages from input word to output word
    localparam int PIPE_LAT = 2 * DIV_STAGES + 12;

    // configuration register indexes
    localparam logic [2:0] REG_CAL_A = 3'd0;
    localparam logic [2:0] REG_CAL_B = 3'd1;
    localparam logic [2:0] REG_CAL_C = 3'd2;
    localparam logic [2:0] REG_CAL_D = 3'd3;
    localparam logic [2:0] REG_OSS   = 3'd4;

    // compensation constants
    localparam logic [31:0] B6_OFFSET  = 32'd4000;
    localparam logic [31:0] P_COEF_A   = 32'd3038;
    localparam logic [31:0] P_COEF_B   = 32'hFFFF_E343; // -7357
    localparam logic [31:0] P_COEF_C   = 32'd3791;
    localparam logic [31:0] B7_SCALE   = 32'd50000;
    localparam logic [31:0] B4_OFFSET  = 32'd32768;

    // side data carried beside the temperature divider
    typedef struct packed {
        logic        err;
        logic        neg;
        logic [31:0] x1;
        logic [31:0] up;
    } tag1_t;

    // side data carried beside the pressure divider
    typedef struct packed {
        logic        err;
        logic        dbl;
        logic [31:0] t;
    } tag2_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
        return 32'($signed(v) >>> n);
    endfunction

endpackage
`default_nettype wire

/* rtl/bpc_div.sv */
`default_nettype none
module bpc_div (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic [31:0]      quotient
);
    import bpc_pkg::*;

    logic [31:0] rem_reg [DIV_STAGES];
    logic [31:0] dd_reg  [DIV_STAGES];
    logic [31:0] dv_reg  [DIV_STAGES];
    logic [31:0] rem_next [DIV_STAGES];
    logic [31:0] dd_next  [DIV_STAGES];

    // one restoring step per stage
    always_comb begin
        logic [31:0] r_in;
        logic [31:0] d_in;
        logic [31:0] v_in;
        logic [32:0] trial;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                r_in = '0;
                d_in = dividend;
                v_in = divisor;
            end else begin
                r_in = rem_reg[k-1];
                d_in = dd_reg[k-1];
                v_in = dv_reg[k-1];
            end
            trial = {r_in, d_in[31]} - {1'b0, v_in};
            if (!trial[32]) begin
                rem_next[k] = trial[31:0];
            end else begin
                rem_next[k] = {r_in[30:0], d_in[31]};
            end
            dd_next[k] = {d_in[30:0], ~trial[32]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_reg[0] <= divisor;
            for (int k = 0; k < DIV_STAGES; k++) begin
                rem_reg[k] <= rem_next[k];
                dd_reg[k]  <= dd_next[k];
            end
            for (int k = 1; k < DIV_STAGES; k++) begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end
    end

    assign quotient = dd_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

/* rtl/barometric_pressure_compensation.sv */
// Barometric pressure compensation, fully pipelined.
// Input stream s_*: one word per sample pair, tdata = raw temperature (bits 15:0)
// and the three raw pressure bytes (bits 39:16). Output stream m_*: tdata =
// temperature in 0.1 degC (15:0, signed) and pressure in Pa (33:16); tuser[0]
// flags a zero divisor, in which case both results are zero.
// Calibration and oversampling are written over the cfg_* channel (index 0..4:
// cal groups a, b, c, d, oversampling); write only while the pipe is empty.
// The path from input word to output word runs through two 32-stage
// bit-per-stage dividers plus twelve multiply/add stages.
// Throughput is one word per cycle; a new word is taken every cycle the
// output register is empty or being drained.
// When m_tready is low with a word waiting, the whole pipe holds and s_tready
// drops; nothing is lost or repeated.
// Synchronous reset (aresetn low) empties the pipe and sets calibration to
// zero and oversampling to three.
`default_nettype none
`include "barometric_pressure_compensation_defines.svh"
module barometric_pressure_compensation (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // raw_temperature, raw_pressure_bytes
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // true_temperature, true_pressure, zero pad
    output logic [0:0]       m_tuser,   // divide_error
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);
    import bpc_pkg::*;

    // configuration registers
    logic [47:0] cal_a_reg, cal_b_reg;
    logic [31:0] cal_c_reg, cal_d_reg;
    logic [1:0]  oss_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            cal_d_reg <= '0;
            oss_reg   <= 2'd3;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CAL_A: cal_a_reg <= cfg_data;
                REG_CAL_B: cal_b_reg <= cfg_data;
                REG_CAL_C: cal_c_reg <= cfg_data[31:0];
                REG_CAL_D: cal_d_reg <= cfg_data[31:0];
                REG_OSS:   oss_reg   <= cfg_data[1:0];
                default:   ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(cal_a_reg[47:32]);
    assign ac2 = sx16(cal_a_reg[31:16]);
    assign ac3 = sx16(cal_a_reg[15:0]);
    assign ac4 = {16'd0, cal_b_reg[47:32]};
    assign ac5 = {16'd0, cal_b_reg[31:16]};
    assign ac6 = {16'd0, cal_b_reg[15:0]};
    assign b1  = sx16(cal_c_reg[31:16]);
    assign b2  = sx16(cal_c_reg[15:0]);
    assign mc  = sx16(cal_d_reg[31:16]);
    assign md  = sx16(cal_d_reg[15:0]);

    // global advance and valid shift line
    logic adv;
    logic [PIPE_LAT-1:0] vld_reg;
    assign adv      = !vld_reg[PIPE_LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[PIPE_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    // stage 0: input register, pressure shift
    logic [31:0] ut0_reg, up0_reg;
    // stage 1: x1 of temperature
    logic [31:0] x1_1_reg, up1_reg;
    logic [31:0] prod_ut;
    assign prod_ut = (ut0_reg - ac6) * ac5;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ut0_reg  <= {16'd0, s_tdata[15:0]};
            up0_reg  <= {8'd0, s_tdata[39:16]} >> (4'd8 - {2'd0, oss_reg});
            x1_1_reg <= asr(prod_ut, 5'd15);
            up1_reg  <= up0_reg;
        end
    end

    // temperature divider, signed through magnitudes
    logic [31:0] den, num, den_abs, num_abs, q1;
    tag1_t tag1_in;
    tag1_t td1_reg [DIV_STAGES];
    assign den     = x1_1_reg + md;
    assign num     = {mc[20:0], 11'd0};
    assign den_abs = den[31] ? (32'd0 - den) : den;
    assign num_abs = num[31] ? (32'd0 - num) : num;
    assign tag1_in = '{err: (den == 32'd0), neg: den[31] ^ num[31],
                       x1: x1_1_reg, up: up1_reg};

    bpc_div u_div_t (
        .aclk     (aclk),
        .en       (adv),
        .dividend (num_abs),
        .divisor  (den_abs),
        .quotient (q1)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            td1_reg[0] <= tag1_in;
            for (int k = 1; k < DIV_STAGES; k++) begin
                td1_reg[k] <= td1_reg[k-1];
            end
        end
    end

    // stage 3: b5, temperature, b6
    tag1_t tg1;
    logic [31:0] x2t, b5;
    assign tg1 = td1_reg[DIV_STAGES-1];
    assign x2t = tg1.neg ? (32'd0 - q1) : q1;
    assign b5  = tg1.x1 + x2t;

    logic        err3_reg, err4_reg, err5_reg, err6_reg, err7_reg, err8_reg;
    logic [31:0] t3_reg, t4_reg, t5_reg, t6_reg, t7_reg, t8_reg;
    logic [31:0] up3_reg, up4_reg, up5_reg, up6_reg, up7_reg;
    logic [31:0] b6_reg;
    logic [31:0] msq_reg, ma2_reg, ma3_reg;
    logic [31:0] sq_reg, x2a5_reg, x1b5_reg, x2a6_reg, x1b6_reg;
    logic [31:0] mb2_reg, mb1_reg;
    logic [31:0] b3_reg, x3p_reg;
    logic [31:0] b4_reg, b7_reg;

    logic [31:0] x3a, b3_next, x3b;
    assign x3a     = asr(mb2_reg, 5'd11) + x2a6_reg;
    assign b3_next = asr((({ac1[29:0], 2'd0} + x3a) << oss_reg) + 32'd2, 5'd2);
    assign x3b     = asr(x1b6_reg + asr(mb1_reg, 5'd16) + 32'd2, 5'd2);

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 3
            err3_reg <= tg1.err;
            t3_reg   <= asr(b5 + 32'd8, 5'd4);
            b6_reg   <= b5 - B6_OFFSET;
            up3_reg  <= tg1.up;
            // stage 4: first products
            err4_reg <= err3_reg;
            t4_reg   <= t3_reg;
            up4_reg  <= up3_reg;
            msq_reg  <= b6_reg * b6_reg;
            ma2_reg  <= ac2 * b6_reg;
            ma3_reg  <= ac3 * b6_reg;
            // stage 5: shifts
            err5_reg <= err4_reg;
            t5_reg   <= t4_reg;
            up5_reg  <= up4_reg;
            sq_reg   <= asr(msq_reg, 5'd12);
            x2a5_reg <= asr(ma2_reg, 5'd11);
            x1b5_reg <= asr(ma3_reg, 5'd13);
            // stage 6: products with sq
            err6_reg <= err5_reg;
            t6_reg   <= t5_reg;
            up6_reg  <= up5_reg;
            mb2_reg  <= b2 * sq_reg;
            mb1_reg  <= b1 * sq_reg;
            x2a6_reg <= x2a5_reg;
            x1b6_reg <= x1b5_reg;
            // stage 7: b3 and x3
            err7_reg <= err6_reg;
            t7_reg   <= t6_reg;
            up7_reg  <= up6_reg;
            b3_reg   <= b3_next;
            x3p_reg  <= x3b + B4_OFFSET;
            // stage 8: b4 and b7
            err8_reg <= err7_reg;
            t8_reg   <= t7_reg;
            b4_reg   <= (ac4 * x3p_reg) >> 15;
            b7_reg   <= (up7_reg - b3_reg) * (B7_SCALE >> oss_reg);
        end
    end

    // pressure divider, unsigned
    logic [31:0] pdiv, q2;
    tag2_t tag2_in;
    tag2_t td2_reg [DIV_STAGES];
    assign pdiv    = b7_reg[31] ? b7_reg : {b7_reg[30:0], 1'b0};
    assign tag2_in = '{err: err8_reg || (b4_reg == 32'd0), dbl: b7_reg[31], t: t8_reg};

    bpc_div u_div_p (
        .aclk     (aclk),
        .en       (adv),
        .dividend (pdiv),
        .divisor  (b4_reg),
        .quotient (q2)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            td2_reg[0] <= tag2_in;
            for (int k = 1; k < DIV_STAGES; k++) begin
                td2_reg[k] <= td2_reg[k-1];
            end
        end
    end

    // final correction stages
    tag2_t tg2;
    assign tg2 = td2_reg[DIV_STAGES-1];

    logic        err9_reg, err10_reg, err11_reg;
    logic [31:0] t9_reg, t10_reg, t11_reg;
    logic [31:0] p9_reg, p10_reg, p11_reg;
    logic [31:0] x1p_sq_reg, m7357_reg, m3038_reg, x2p_reg;
    logic [31:0] x1p;
    assign x1p = asr(p9_reg, 5'd8);

    logic [31:0] p_fin;
    logic [15:0] t_sat;
    logic [17:0] p_sat;
    assign p_fin = p11_reg + asr(asr(m3038_reg, 5'd16) + x2p_reg + P_COEF_C, 5'd4);

    // saturation to output ranges
    always_comb begin
        if ($signed(t11_reg) > 32'sd32767) begin
            t_sat = 16'h7FFF;
        end else if ($signed(t11_reg) < -32'sd32768) begin
            t_sat = 16'h8000;
        end else begin
            t_sat = t11_reg[15:0];
        end
        if (p_fin[31]) begin
            p_sat = '0;
        end else if (p_fin > 32'd262143) begin
            p_sat = '1;
        end else begin
            p_sat = p_fin[17:0];
        end
    end

    logic [15:0] tt_reg;
    logic [17:0] tp_reg;
    logic        de_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            err9_reg   <= tg2.err;
            t9_reg     <= tg2.t;
            p9_reg     <= tg2.dbl ? {q2[30:0], 1'b0} : q2;
            err10_reg  <= err9_reg;
            t10_reg    <= t9_reg;
            p10_reg    <= p9_reg;
            x1p_sq_reg <= x1p * x1p;
            m7357_reg  <= P_COEF_B * p9_reg;
            err11_reg  <= err10_reg;
            t11_reg    <= t10_reg;
            p11_reg    <= p10_reg;
            m3038_reg  <= x1p_sq_reg * P_COEF_A;
            x2p_reg    <= asr(m7357_reg, 5'd16);
            tt_reg     <= err11_reg ? 16'd0 : t_sat;
            tp_reg     <= err11_reg ? 18'd0 : p_sat;
            de_reg     <= err11_reg;
        end
    end

    assign m_tdata = {6'd0, tp_reg, tt_reg};
    assign m_tuser = de_reg;

    `BPC_ASSERT_NOW(a_err_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 40'd0)
    `BPC_ASSERT_NOW(a_hold_input, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `BPC_ASSERT_NEXT(a_stall_keeps, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

endmodule
`default_nettype wire

/* tb/sv/barometric_pressure_compensation_tb.sv */
`timescale 1ns / 100ps
module barometric_pressure_compensation_tb;
    import bpc_pkg::*;

    localparam int CLK_HALF = 4;
    localparam int NUM_RANDOM = 1800;
    localparam int DRAIN_CYCLES = PIPE_LAT + 20;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [23:0] press_raw;
        logic [15:0] temp_raw;
    } sample_t;

    typedef struct {
        logic signed [15:0] temp;
        logic [17:0]        press;
        logic               div_err;
    } reading_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [39:0] s_tdata = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [39:0] m_tdata;
    wire  [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;

    // calibration shadow used by the predictor
    logic [47:0] cal_a, cal_b;
    logic [31:0] cal_c, cal_d;
    logic [1:0]  oss;

    sample_t  sample_q[$];
    reading_t reading_q[$];
    int       mismatches = 0;
    int       readings_seen = 0;
    int       div_errors_seen = 0;
    longint   cycle_count = 0;
    bit       stim_done = 0;
    bit       quiet_phase = 0;
    bit       in_acc = 0;
    int       src_gap = 0;
    int       sink_gap = 0;

    barometric_pressure_compensation DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    function automatic logic [31:0] shr_arith(logic [31:0] v, int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
        longint q;
        q = longint'($signed(a)) / longint'($signed(b));
        return q[31:0];
    endfunction

    function automatic logic [31:0] ext16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // compensated temperature and pressure for one raw sample pair
    function automatic reading_t compensate(sample_t s);
        reading_t r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, sq, p, t, den;
        longint ts, ps;
        ac1 = ext16(cal_a[47:32]); ac2 = ext16(cal_a[31:16]); ac3 = ext16(cal_a[15:0]);
        ac4 = {16'd0, cal_b[47:32]}; ac5 = {16'd0, cal_b[31:16]}; ac6 = {16'd0, cal_b[15:0]};
        b1 = ext16(cal_c[31:16]); b2 = ext16(cal_c[15:0]);
        mc = ext16(cal_d[31:16]); md = ext16(cal_d[15:0]);
        ut = {16'd0, s.temp_raw};
        up = {8'd0, s.press_raw} >> (8 - oss);
        r.temp = '0; r.press = '0; r.div_err = 1'b1;
        x1 = shr_arith((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        x2 = div_trunc(mc * 32'd2048, den);
        b5 = x1 + x2;
        t = shr_arith(b5 + 32'd8, 4);
        b6 = b5 - B6_OFFSET;
        sq = shr_arith(b6 * b6, 12);
        x1 = shr_arith(b2 * sq, 11);
        x2 = shr_arith(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = shr_arith(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
        x1 = shr_arith(ac3 * b6, 13);
        x2 = shr_arith(b1 * sq, 16);
        x3 = shr_arith(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + B4_OFFSET)) >> 15;
        if (b4 == 0) return r;
        b7 = (up - b3) * (B7_SCALE >> oss);
        if (!b7[31]) p = (b7 << 1) / b4;
        else p = (b7 / b4) << 1;
        x1 = shr_arith(p, 8);
        x1 = x1 * x1;
        x1 = shr_arith(x1 * P_COEF_A, 16);
        x2 = shr_arith(P_COEF_B * p, 16);
        p = p + shr_arith(x1 + x2 + P_COEF_C, 4);
        ts = $signed(t);
        if (ts > 32767) ts = 32767;
        if (ts < -32768) ts = -32768;
        ps = $signed(p);
        if (ps > 262143) ps = 262143;
        if (ps < 0) ps = 0;
        r.temp = ts[15:0];
        r.press = ps[17:0];
        r.div_err = 1'b0;
        return r;
    endfunction

    // driver: one sample word per handshake, random gaps
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_acc) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                    src_gap <= $urandom_range(0, 4);
                    s_tvalid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= sample_q[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            // receiver stalls
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn) begin
            cycle_count <= cycle_count + 1;
            // accepted sample word: queue its prediction
            in_acc <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                reading_q.push_back(compensate(sample_q.pop_front()));
            end
            if (m_tvalid && m_tready) begin
                readings_seen <= readings_seen + 1;
                if (reading_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected word %h", m_tdata);
                end else begin
                    want = reading_q.pop_front();
                    if (want.div_err) div_errors_seen <= div_errors_seen + 1;
                    if (m_tdata[15:0] !== want.temp || m_tdata[33:16] !== want.press
                            || m_tuser[0] !== want.div_err) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp t=%0d p=%0d e=%b got t=%0d p=%0d e=%b",
                                want.temp, want.press, want.div_err,
                                $signed(m_tdata[15:0]), m_tdata[33:16], m_tuser[0]);
                    end
                end
            end
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_CAL_A: cal_a = val;
            REG_CAL_B: cal_b = val;
            REG_CAL_C: cal_c = val[31:0];
            REG_CAL_D: cal_d = val[31:0];
            REG_OSS:   oss = val[1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // block until every queued sample has been answered, then let the pipe settle
    task automatic wait_drained();
        while (sample_q.size() > 0 || s_tvalid || reading_q.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // typical calibration, or fully random calibration words
    task automatic load_calibration(bit typical, logic [1:0] os);
        if (typical) begin
            write_reg(REG_CAL_A, {16'd408, -16'sd72, -16'sd14383});
            write_reg(REG_CAL_B, {16'd32741, 16'd32757, 16'd23153});
            write_reg(REG_CAL_C, {16'd0, 16'd6190, 16'd4});
            write_reg(REG_CAL_D, {16'd0, -16'sd8711, 16'd2868});
        end else begin
            write_reg(REG_CAL_A, 48'({$urandom, $urandom}));
            write_reg(REG_CAL_B, 48'({$urandom, $urandom}));
            write_reg(REG_CAL_C, {16'd0, $urandom});
            write_reg(REG_CAL_D, {16'd0, $urandom});
        end
        write_reg(REG_OSS, {46'd0, os});
    endtask

    function automatic sample_t near_typical();
        sample_t s;
        s.temp_raw = 16'(16'd27898 + $urandom_range(0, 4000) - 2000);
        s.press_raw = {16'd23843 + 16'($urandom_range(0, 8000)) - 16'd4000, 8'($urandom)};
        return s;
    endfunction

    initial begin
        sample_t s;
        int phase;
        cal_a = '0; cal_b = '0; cal_c = '0; cal_d = '0; oss = 2'd3;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset calibration: every divisor zero
        sample_q.push_back('{24'hFFFFFF, 16'hFFFF});
        sample_q.push_back('{24'h000000, 16'h0000});
        wait_drained();

        // directed: field extremes on typical calibration at each setting
        for (int os = 0; os < 4; os++) begin
            load_calibration(1, os[1:0]);
            sample_q.push_back('{24'h000000, 16'h0000});
            sample_q.push_back('{24'hFFFFFF, 16'hFFFF});
            sample_q.push_back('{24'h5D2300, 16'd27898});
            sample_q.push_back('{24'hAAAAAA, 16'h5555});
            sample_q.push_back('{24'h555555, 16'hAAAA});
            wait_drained();
        end

        // temperature divisor zero: md cancels x1 (ac5 zero -> x1 zero, md zero)
        write_reg(REG_CAL_B, {16'd32741, 16'd0, 16'd23153});
        write_reg(REG_CAL_D, {16'd0, -16'sd8711, 16'd0});
        sample_q.push_back('{24'h123456, 16'h1234});
        wait_drained();
        // pressure divisor zero: ac4 zero; most negative mc over a divisor of minus one
        write_reg(REG_CAL_B, {16'd0, 16'd32757, 16'd23153});
        write_reg(REG_CAL_D, {16'd0, 16'h8000, 16'hFFFF});
        sample_q.push_back('{24'h123456, 16'd23153});
        wait_drained();

        // random phases: mostly typical calibration, some wild
        for (phase = 0; phase < 12; phase++) begin
            load_calibration(phase % 3 != 2, 2'($urandom_range(0, 3)));
            if (phase == 11) quiet_phase = 1;
            for (int i = 0; i < NUM_RANDOM / 12; i++) begin
                if ($urandom_range(0, 3) != 0) s = near_typical();
                else s = 40'({$urandom, $urandom});
                sample_q.push_back(s);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("checked %0d readings: field extremes, both zero divisors, twelve calibrations",
            readings_seen);
        $display("with random idling on both sides; %0d readings flagged a divide error",
            div_errors_seen);
        if (mismatches == 0 && reading_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_div.sv
rtl/barometric_pressure_compensation.sv
tb/sv/barometric_pressure_compensation_tb.sv
